FILE: rtl/urr_pkg.sv
// shared types and constants of the ultrasonic echo ranger
`default_nettype none

package urr_pkg;

  // sizing
  localparam int unsigned TimerWidthDef = 17;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned DistW         = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTriggerTicks = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTickUs       = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeoutUs    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgUsPerCm      = 8'd3;

  // configuration reset values
  localparam logic [7:0]  TriggerTicksRst = 8'd1;
  localparam logic [9:0]  TickUsRst       = 10'd10;
  localparam logic [15:0] TimeoutUsRst    = 16'd46400;
  localparam logic [7:0]  UsPerCmRst      = 8'd58;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [9:0]  tick_us;
    logic [15:0] tmo_limit;
    logic [7:0]  us_per_cm;
  } urr_cfg_t;

  // per-tick result flags handed from front to back
  typedef struct packed {
    logic trigger_level;
    logic result_valid;
    logic timed_out;
    logic busy_res;
    logic need_div;
  } urr_flags_t;

endpackage

`default_nettype wire

FILE: rtl/urr_if.sv
// handshake channel interfaces of the ultrasonic echo ranger
`default_nettype none

interface urr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;
  modport source (output valid, start_req, echo_level, input ready);
  modport sink (input valid, start_req, echo_level, output ready);
endinterface

interface urr_out_if;
  import urr_pkg::*;
  logic             valid;
  logic             ready;
  logic             trigger_level;
  logic             result_valid;
  logic             timed_out;
  logic [DistW-1:0] distance_cm;
  logic             busy_res;
  modport source (output valid, trigger_level, result_valid, timed_out, distance_cm, busy_res,
                  input ready);
  modport sink (input valid, trigger_level, result_valid, timed_out, distance_cm, busy_res,
                output ready);
endinterface

interface urr_cfg_if;
  import urr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic time-of-flight ranger, one input transaction per poll tick, one result each.
// Path: an accepted tick is written into the queue, popped by the back end and registered
// into the output; a distance first passes the restoring divider, one quotient bit per cycle.
// Throughput: one tick per cycle while the queue is not full; its QUEUE_DEPTH entries (two
// by default) let the front keep accepting while a finishing tick holds the divider.
// Reset: asynchronous, active low; idle phase, timers cleared, registers to defaults.
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int unsigned TIMER_WIDTH = urr_pkg::TimerWidthDef,
  parameter int unsigned QUEUE_DEPTH = urr_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  urr_cfg_if.sink   cfg_i,
  urr_in_if.sink    in_i,
  urr_out_if.source out_o
);
  import urr_pkg::*;

  localparam int unsigned EntW = $bits(urr_flags_t) + TIMER_WIDTH + 8;

  urr_cfg_t               cfg_q;
  logic                   push, full, pop, empty;
  urr_flags_t             f_flags, b_flags;
  logic [TIMER_WIDTH-1:0] f_dividend, b_dividend;
  logic [7:0]             f_divisor, b_divisor;
  logic [EntW-1:0]        q_wdata, q_rdata;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TriggerTicksRst;
      cfg_q.tick_us       <= TickUsRst;
      cfg_q.tmo_limit     <= TimeoutUsRst;
      cfg_q.us_per_cm     <= UsPerCmRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgTriggerTicks: cfg_q.trigger_ticks <= cfg_i.data[7:0];
        CfgTickUs:       cfg_q.tick_us       <= cfg_i.data[9:0];
        CfgTimeoutUs:    cfg_q.tmo_limit     <= cfg_i.data[15:0];
        CfgUsPerCm:      cfg_q.us_per_cm     <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: sequencing
  urr_front #(
    .TimerWidth (TIMER_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .flags_o    (f_flags),
    .dividend_o (f_dividend),
    .divisor_o  (f_divisor)
  );

  // queue between front and back
  assign q_wdata = {f_flags, f_dividend, f_divisor};
  assign {b_flags, b_dividend, b_divisor} = q_rdata;

  urr_queue #(
    .Width (EntW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  // back: division and output
  urr_back #(
    .TimerWidth (TIMER_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .flags_i    (b_flags),
    .dividend_i (b_dividend),
    .divisor_i  (b_divisor),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/urr_front.sv
// front end: per-tick phase sequencing, timers and timeout checks
`default_nettype none

module urr_front #(
  parameter int unsigned TimerWidth = urr_pkg::TimerWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  urr_pkg::urr_cfg_t     cfg_i,
  urr_in_if.sink                in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output urr_pkg::urr_flags_t   flags_o,
  output logic [TimerWidth-1:0] dividend_o,
  output logic [7:0]            divisor_o
);
  import urr_pkg::*;

  localparam int unsigned CmpW = (TimerWidth > 16) ? TimerWidth : 16;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhTrig  = 2'd1;
  localparam logic [1:0] PhWait  = 2'd2;
  localparam logic [1:0] PhPulse = 2'd3;

  logic [1:0]            phase_q, phase_d;
  logic [7:0]            trig_cnt_q, trig_cnt_d;
  logic [TimerWidth-1:0] wait_q, wait_d;
  logic [TimerWidth-1:0] pulse_q, pulse_d;

  logic                  accept;
  logic [TimerWidth-1:0] tick_ext;
  logic [TimerWidth:0]   wait_sum, pulse_sum;
  logic [TimerWidth-1:0] wait_add, pulse_add;
  logic                  wait_over, pulse_over;
  logic [7:0]            trig_len, trig_next;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;
  assign dividend_o = pulse_add;
  assign divisor_o  = cfg_i.us_per_cm;

  // saturating timer additions and timeout compares
  always_comb begin
    tick_ext   = TimerWidth'(cfg_i.tick_us);
    wait_sum   = {1'b0, wait_q} + {1'b0, tick_ext};
    pulse_sum  = {1'b0, pulse_q} + {1'b0, tick_ext};
    wait_add   = wait_sum[TimerWidth] ? '1 : wait_sum[TimerWidth-1:0];
    pulse_add  = pulse_sum[TimerWidth] ? '1 : pulse_sum[TimerWidth-1:0];
    wait_over  = CmpW'(wait_add) > CmpW'(cfg_i.tmo_limit);
    pulse_over = CmpW'(pulse_add) > CmpW'(cfg_i.tmo_limit);
    trig_len   = (cfg_i.trigger_ticks == 8'd0) ? 8'd1 : cfg_i.trigger_ticks;
    trig_next  = trig_cnt_q + 8'd1;
  end

  // phase sequencing
  always_comb begin
    phase_d    = phase_q;
    trig_cnt_d = trig_cnt_q;
    wait_d     = wait_q;
    pulse_d    = pulse_q;
    flags_o    = '0;
    case (phase_q)
      PhIdle: begin
        if (in_i.start_req) begin
          flags_o.trigger_level = 1'b1;
          trig_cnt_d            = 8'd1;
          wait_d                = '0;
          pulse_d               = '0;
          phase_d               = (trig_len <= 8'd1) ? PhWait : PhTrig;
        end
      end
      PhTrig: begin
        flags_o.trigger_level = 1'b1;
        trig_cnt_d            = trig_next;
        if (trig_next >= trig_len || trig_next == 8'd0) begin
          phase_d = PhWait;
        end
      end
      PhWait: begin
        wait_d = wait_add;
        if (wait_over) begin
          flags_o.result_valid = 1'b1;
          flags_o.timed_out    = 1'b1;
          phase_d              = PhIdle;
        end else if (in_i.echo_level) begin
          pulse_d = '0;
          phase_d = PhPulse;
        end
      end
      PhPulse: begin
        pulse_d = pulse_add;
        if (pulse_over) begin
          flags_o.result_valid = 1'b1;
          flags_o.timed_out    = 1'b1;
          phase_d              = PhIdle;
        end else if (!in_i.echo_level) begin
          flags_o.result_valid = 1'b1;
          flags_o.need_div     = 1'b1;
          phase_d              = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    flags_o.busy_res = (phase_d != PhIdle);
  end

  // state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      trig_cnt_q <= '0;
      wait_q     <= '0;
      pulse_q    <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      trig_cnt_q <= trig_cnt_d;
      wait_q     <= wait_d;
      pulse_q    <= pulse_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/urr_queue.sv
// short register queue between front and back
`default_nettype none

module urr_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = urr_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  import urr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/urr_back.sv
// back end: bit-serial distance division and output register
`default_nettype none

module urr_back #(
  parameter int unsigned TimerWidth = urr_pkg::TimerWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  urr_pkg::urr_flags_t   flags_i,
  input  logic [TimerWidth-1:0] dividend_i,
  input  logic [7:0]            divisor_i,
  output logic                  pop_o,
  urr_out_if.source             out_o
);
  import urr_pkg::*;

  localparam int unsigned CntW = $clog2(TimerWidth + 1);
  localparam int unsigned QW   = (TimerWidth > DistW) ? TimerWidth : DistW;

  logic                  div_busy_q, div_busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [7:0]            rem_q, rem_d;
  logic [TimerWidth-1:0] quot_q, quot_d;
  logic [7:0]            div_q, div_d;
  urr_flags_t            hold_q, hold_d;

  logic                  out_valid_q, out_valid_d;
  urr_flags_t            res_q, res_d;
  logic [DistW-1:0]      dist_q, dist_d;

  logic                  out_free;
  logic [8:0]            shifted;
  logic [8:0]            trial;
  logic [QW-1:0]         quot_ext;
  logic [DistW-1:0]      quot_sat;

  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = !div_busy_q && !empty_i && (flags_i.need_div || out_free);

  // one quotient bit per cycle, restoring; a zero divisor yields all ones
  always_comb begin
    shifted  = {rem_q, quot_q[TimerWidth-1]};
    trial    = shifted - {1'b0, div_q};
    quot_ext = QW'(quot_q);
    quot_sat = ((quot_ext >> DistW) != '0) ? '1 : quot_ext[DistW-1:0];
  end

  // divider control and result loading
  always_comb begin
    div_busy_d  = div_busy_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    div_d       = div_q;
    hold_d      = hold_q;
    res_d       = res_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (pop_o) begin
      if (flags_i.need_div) begin
        div_busy_d = 1'b1;
        cnt_d      = CntW'(TimerWidth);
        rem_d      = '0;
        quot_d     = dividend_i;
        div_d      = divisor_i;
        hold_d     = flags_i;
      end else begin
        res_d       = flags_i;
        dist_d      = '0;
        out_valid_d = 1'b1;
      end
    end else if (div_busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        if (shifted >= {1'b0, div_q}) begin
          rem_d  = trial[7:0];
          quot_d = {quot_q[TimerWidth-2:0], 1'b1};
        end else begin
          rem_d  = shifted[7:0];
          quot_d = {quot_q[TimerWidth-2:0], 1'b0};
        end
      end else if (out_free) begin
        div_busy_d  = 1'b0;
        res_d       = hold_q;
        dist_d      = (div_q == 8'd0) ? '1 : quot_sat;
        out_valid_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      div_busy_q  <= div_busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    dist_q <= dist_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.trigger_level = res_q.trigger_level;
  assign out_o.result_valid  = res_q.result_valid;
  assign out_o.timed_out     = res_q.timed_out;
  assign out_o.busy_res      = res_q.busy_res;
  assign out_o.distance_cm   = dist_q;

endmodule

`default_nettype wire
